### rtl/core/salru_pkg.sv
// Shared constants, types and helpers for the set-associative LRU cache lookup.
`timescale 1ns / 1ps

package salru_pkg;

	// Geometry limits
	localparam int MAX_SET_BITS = 6;
	localparam int MAX_WAYS     = 8;
	localparam int NUM_SETS     = 1 << MAX_SET_BITS;

	localparam int SET_IW  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_IW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int RANK_W  = WAY_IW;
	localparam int SB_W    = (MAX_SET_BITS > 0) ? $clog2(MAX_SET_BITS + 1) : 1;

	// Field widths
	localparam int ADDR_W     = 64;
	localparam int TAG_W      = 64;
	localparam int SHIFT_W    = 7;
	localparam int WAY_OUT_W  = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// Request queue between front and back end
	localparam int QUEUE_DEPTH = 2;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SET_BITS     = 2'd0,
		CFG_WAY_BITS     = 2'd1,
		CFG_BLOCK_BITS   = 2'd2,
		CFG_ADDRESS_BITS = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [2:0] set_bits;
		logic [1:0] way_bits;
		logic [5:0] block_bits;
		logic [6:0] address_bits;
	} cfg_t;

	// Classified request handed from front to back end
	typedef struct packed {
		logic [SET_IW-1:0] set_idx;
		logic [TAG_W-1:0]  tag;
		logic              in_range;
	} req_t;

	// Per-way metadata, one row per set
	typedef struct packed {
		logic              vld;
		logic [RANK_W-1:0] rank;
	} meta_way_t;

	typedef meta_way_t [MAX_WAYS-1:0] meta_row_t;
	typedef logic [MAX_WAYS-1:0][TAG_W-1:0] tag_row_t;

	localparam int META_ROW_W = $bits(meta_row_t);
	localparam int TAG_ROW_W  = $bits(tag_row_t);

	// Ways in use for a given log2 way count, capped at MAX_WAYS
	function automatic logic [MAX_WAYS-1:0] active_mask(logic [1:0] wb);
		logic [MAX_WAYS-1:0] m;
		for (int w = 0; w < MAX_WAYS; w++) begin
			m[w] = (w < (32'd1 << wb));
		end
		return m;
	endfunction

endpackage

### rtl/core/salru_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module salru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/core/salru_front.sv
// Front end: takes addresses, range-checks them and splits them into set and tag.
`timescale 1ns / 1ps

module salru_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [salru_pkg::ADDR_W-1:0]    address,
	input  salru_pkg::cfg_t                 cfg,
	output logic                            busy,
	output logic                            q_push,
	output salru_pkg::req_t                 q_data,
	input  logic                            q_full
);

	import salru_pkg::*;

	logic              valid_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [SB_W-1:0]   sb;
	logic [SET_IW-1:0] set_mask;
	logic [SHIFT_W-1:0] tag_shift;
	logic              take;

	// Hold off new transactions only while the staged one cannot move on
	assign busy   = valid_s1 && q_full;
	assign take   = start && !busy;
	assign q_push = valid_s1 && !q_full;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			addr_s1 <= address;
		end
	end

	// Set bits saturate at the implemented maximum
	always_comb begin
		if (int'(cfg.set_bits) > MAX_SET_BITS) begin
			sb = SB_W'(MAX_SET_BITS);
		end else begin
			sb = SB_W'(cfg.set_bits);
		end
		for (int i = 0; i < SET_IW; i++) begin
			set_mask[i] = (i < int'(sb));
		end
	end

	// Classification; shifts of 64 or more yield zero
	always_comb begin
		tag_shift       = SHIFT_W'(sb) + SHIFT_W'(cfg.block_bits);
		q_data.in_range = ((addr_s1 >> cfg.address_bits) == '0);
		q_data.set_idx  = SET_IW'(addr_s1 >> cfg.block_bits) & set_mask;
		if (tag_shift >= SHIFT_W'(ADDR_W)) begin
			q_data.tag = '0;
		end else begin
			q_data.tag = addr_s1 >> tag_shift;
		end
	end

endmodule

### rtl/core/salru_queue.sv
// Short request queue decoupling the front end from the back end.
`timescale 1ns / 1ps

module salru_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  salru_pkg::req_t push_data,
	output logic            full,
	input  logic            pop,
	output salru_pkg::req_t pop_data,
	output logic            empty
);

	import salru_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	req_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = entry_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### rtl/core/salru_back.sv
// Back end: reads a set, resolves hit/fill/evict, updates ages and tags, reports.
`timescale 1ns / 1ps

module salru_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  salru_pkg::cfg_t                   cfg,
	input  logic                              q_empty,
	input  salru_pkg::req_t                   q_data,
	output logic                              q_pop,
	output logic                              done,
	output logic                              hit,
	output logic                              in_range,
	output logic                              evicted,
	output logic [salru_pkg::WAY_OUT_W-1:0]   way_used
);

	import salru_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE    = 2'b01,
		ST_RESOLVE = 2'b10
	} state_t;

	state_t               state_q;
	req_t                 req_s2;
	logic                 init_s2;
	logic [NUM_SETS-1:0]  init_q;

	logic [META_ROW_W-1:0] meta_rdata;
	logic [TAG_ROW_W-1:0]  tag_rdata;
	logic                  meta_we;
	logic                  tag_we;

	logic [MAX_WAYS-1:0] act;
	meta_row_t           row;
	meta_row_t           new_row;
	tag_row_t            trow;
	tag_row_t            new_trow;
	logic                hit_any;
	logic                free_any;
	logic [WAY_IW-1:0]   hit_way;
	logic [WAY_IW-1:0]   free_way;
	logic [WAY_IW-1:0]   victim;
	logic [WAY_IW-1:0]   sel;
	logic [RANK_W-1:0]   old_rank;
	logic                age_all;

	logic                 done_q;
	logic                 hit_q;
	logic                 in_range_q;
	logic                 evicted_q;
	logic [WAY_OUT_W-1:0] way_q;

	assign q_pop   = (state_q == ST_IDLE) && !q_empty;
	assign meta_we = (state_q == ST_RESOLVE) && req_s2.in_range;
	assign tag_we  = meta_we && !hit_any;

	// Valid bits and ages, one row per set
	salru_ram #(
		.WIDTH(META_ROW_W),
		.DEPTH(NUM_SETS)
	) u_meta_ram (
		.clk    (clk),
		.wr_en  (meta_we),
		.wr_addr(req_s2.set_idx),
		.wr_data(META_ROW_W'(new_row)),
		.rd_en  (q_pop),
		.rd_addr(q_data.set_idx),
		.rd_data(meta_rdata)
	);

	// Tags, one row per set
	salru_ram #(
		.WIDTH(TAG_ROW_W),
		.DEPTH(NUM_SETS)
	) u_tag_ram (
		.clk    (clk),
		.wr_en  (tag_we),
		.wr_addr(req_s2.set_idx),
		.wr_data(TAG_ROW_W'(new_trow)),
		.rd_en  (q_pop),
		.rd_addr(q_data.set_idx),
		.rd_data(tag_rdata)
	);

	// Sequencer: the set is read as a request leaves ST_IDLE, then resolved and written back in ST_RESOLVE
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			init_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_RESOLVE;
					end
				end
				ST_RESOLVE: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
					if (meta_we) begin
						init_q[req_s2.set_idx] <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request and row-written flag travel with the RAM read
	always_ff @(posedge clk) begin
		if (q_pop) begin
			req_s2  <= q_data;
			init_s2 <= init_q[q_data.set_idx];
		end
	end

	// Lookup, replacement choice and age update
	always_comb begin
		act      = active_mask(cfg.way_bits);
		row      = init_s2 ? meta_row_t'(meta_rdata) : '0;
		trow     = tag_row_t'(tag_rdata);
		hit_any  = 1'b0;
		free_any = 1'b0;
		hit_way  = '0;
		free_way = '0;

		// Lowest matching way and lowest free way
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (act[w] && row[w].vld && (trow[w] == req_s2.tag)) begin
				hit_any = 1'b1;
				hit_way = WAY_IW'(w);
			end
			if (act[w] && !row[w].vld) begin
				free_any = 1'b1;
				free_way = WAY_IW'(w);
			end
		end

		// Oldest way, ties to the lowest
		victim = '0;
		for (int w = 1; w < MAX_WAYS; w++) begin
			if (act[w] && (row[w].rank > row[victim].rank)) begin
				victim = WAY_IW'(w);
			end
		end

		priority if (hit_any) begin
			sel = hit_way;
		end else if (free_any) begin
			sel = free_way;
		end else begin
			sel = victim;
		end

		// A fresh fill counts as the youngest, so every other valid way ages
		old_rank = row[sel].rank;
		age_all  = !hit_any && free_any;
		new_row  = row;
		for (int v = 0; v < MAX_WAYS; v++) begin
			if (act[v] && (WAY_IW'(v) != sel) && row[v].vld &&
			    (age_all || (row[v].rank < old_rank)) &&
			    (row[v].rank < RANK_W'(MAX_WAYS - 1))) begin
				new_row[v].rank = row[v].rank + RANK_W'(1);
			end
		end
		new_row[sel].vld  = 1'b1;
		new_row[sel].rank = '0;

		new_trow      = trow;
		new_trow[sel] = req_s2.tag;
	end

	// Result register
	always_ff @(posedge clk) begin
		if (state_q == ST_RESOLVE) begin
			hit_q      <= req_s2.in_range && hit_any;
			in_range_q <= req_s2.in_range;
			evicted_q  <= req_s2.in_range && !hit_any && !free_any;
			way_q      <= req_s2.in_range ? WAY_OUT_W'(sel) : '0;
		end
	end

	assign done     = done_q;
	assign hit      = hit_q;
	assign in_range = in_range_q;
	assign evicted  = evicted_q;
	assign way_used = way_q;

endmodule

### rtl/core/set_assoc_lru_cache_lookup.sv
// Top level of the tag-only set-associative cache lookup with LRU replacement.
//
//   Channel   Signals                                   Dir  Transfer
//   request   start, busy, address                      in   start && !busy
//   result    done, hit, in_range, evicted, way_used    out  done (one cycle)
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data in   cfg_valid && cfg_ready
//
// Each set access is a read-modify-write: the back end reads a set's tag and age
// rows, resolves the request and, for an in-range address, writes back the age
// row and on a miss the tag row, before it pops the next request. An accepted
// address is registered, queued, read and resolved before done pulses.
// Reset needs no clearing pass: one flag per set marks rows never written,
// which read as all invalid. A two-entry queue lets the front end keep taking
// requests while the back end works; results cannot be stalled.
`timescale 1ns / 1ps

module set_assoc_lru_cache_lookup (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [salru_pkg::ADDR_W-1:0]      address,
	output logic                              done,
	output logic                              hit,
	output logic                              in_range,
	output logic                              evicted,
	output logic [salru_pkg::WAY_OUT_W-1:0]   way_used,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [salru_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [salru_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import salru_pkg::*;

	cfg_t cfg_q;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	req_t q_in;
	req_t q_out;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.set_bits     <= 3'd6;
			cfg_q.way_bits     <= 2'd3;
			cfg_q.block_bits   <= 6'd6;
			cfg_q.address_bits <= 7'd64;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SET_BITS:     cfg_q.set_bits     <= cfg_data[2:0];
				CFG_WAY_BITS:     cfg_q.way_bits     <= cfg_data[1:0];
				CFG_BLOCK_BITS:   cfg_q.block_bits   <= cfg_data[5:0];
				CFG_ADDRESS_BITS: cfg_q.address_bits <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	salru_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.address(address),
		.cfg    (cfg_q),
		.busy   (busy),
		.q_push (q_push),
		.q_data (q_in),
		.q_full (q_full)
	);

	salru_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_in),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_out),
		.empty    (q_empty)
	);

	salru_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (q_empty),
		.q_data  (q_out),
		.q_pop   (q_pop),
		.done    (done),
		.hit     (hit),
		.in_range(in_range),
		.evicted (evicted),
		.way_used(way_used)
	);

endmodule
